### sv/sbp_pkg.sv
// Shared types and constants for the six-button pad interface.
// No dependencies; imported by sbp_line_map and six_button_pad_bank_mux.
`default_nettype none

package sbp_pkg;

  // Request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_SELECT = 2'd0,
    REQ_BUTTON = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_NOP    = 2'd3
  } req_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_TIMEOUT    = 2'd0,
    CFG_SWITCH_OFF = 2'd1,
    CFG_WRAP       = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  // Button positions in the held vector
  localparam int unsigned NumButtons = 12;
  localparam int unsigned BtnUp      = 0;
  localparam int unsigned BtnDown    = 1;
  localparam int unsigned BtnLeft    = 2;
  localparam int unsigned BtnRight   = 3;
  localparam int unsigned BtnA       = 4;
  localparam int unsigned BtnB       = 5;
  localparam int unsigned BtnC       = 6;
  localparam int unsigned BtnStart   = 7;
  localparam int unsigned BtnX       = 8;
  localparam int unsigned BtnY       = 9;
  localparam int unsigned BtnZ       = 10;
  localparam int unsigned BtnMode    = 11;

  localparam int unsigned TickW   = 24;
  localparam int unsigned BankW   = 3;
  localparam int unsigned WrapW   = 4;

  localparam logic [TickW-1:0] TickMax      = '1;
  localparam logic [TickW-1:0] TimeoutReset = 24'd1600;
  localparam logic [WrapW-1:0] WrapReset    = 4'd4;

  // Bank codes with their own line maps
  localparam logic [BankW-1:0] BankTwo   = 3'd2;
  localparam logic [BankW-1:0] BankThree = 3'd3;

  typedef logic [NumButtons-1:0] buttons_t;

  // Levels on the pad port
  typedef struct packed {
    logic [3:0] data;
    logic       tl;
    logic       tr;
    logic       th;
  } lines_t;

endpackage

`default_nettype wire

### sv/sbp_line_map.sv
// Line multiplexer: maps button state, select level and bank to pad line levels.
// Depends on sbp_pkg.
`default_nettype none

module sbp_line_map
  import sbp_pkg::*;
(
  input  wire buttons_t         buttons,
  input  wire logic             sel_level,
  input  wire logic [BankW-1:0] bank,
  output lines_t                lines
);

  buttons_t lvl;

  // Lines are active low: a pressed button reads 0
  assign lvl = ~buttons;

  always_comb begin
    lines = '0;
    if (bank <= BankThree) begin
      lines.th = 1'b1;
      if (sel_level) begin
        lines.tl = lvl[BtnB];
        lines.tr = lvl[BtnC];
        if (bank == BankThree) begin
          lines.data = {lvl[BtnMode], lvl[BtnX], lvl[BtnY], lvl[BtnZ]};
        end else begin
          lines.data = {lvl[BtnRight], lvl[BtnLeft], lvl[BtnDown], lvl[BtnUp]};
        end
      end else begin
        lines.tl = lvl[BtnA];
        lines.tr = lvl[BtnStart];
        if (bank == BankThree) begin
          lines.data = 4'hF;
        end else if (bank == BankTwo) begin
          lines.data = 4'h0;
        end else begin
          lines.data = {2'b00, lvl[BtnDown], lvl[BtnUp]};
        end
      end
    end
  end

endmodule

`default_nettype wire

### sv/six_button_pad_bank_mux.sv
// Six-button pad interface top level: state update, config registers, result register.
// Depends on sbp_pkg and sbp_line_map.
// The result is registered: it is valid in the output register in the cycle after the input transfer.
// Throughput: one item per cycle; the output register holds a stalled result and
// input ready follows output ready when that register is full.
// Reset (synchronous, rst_n low): no buttons held, select low, bank 0, tick count 0,
// timeout 1600, bank switching on, wrap 4, output register empty.
`default_nettype none

module six_button_pad_bank_mux
  import sbp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input channel
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_req_type,
  input  wire logic             in_th_level,
  input  wire logic [3:0]       in_button_index,
  input  wire logic             in_button_down,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [3:0]            out_data_lines,
  output logic                  out_line_tl,
  output logic                  out_line_tr,
  output logic                  out_line_th,
  output logic [BankW-1:0]      out_bank_now,
  // configuration port
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [TickW-1:0] cfg_wdata
);

  // Next bank after a rising edge: (bank + 1) mod wrap, kept in 3 bits
  function automatic logic [BankW-1:0] wrap_next(input logic [BankW-1:0] bank,
                                                  input logic [WrapW-1:0] wrap);
    logic [WrapW-1:0] inc;
    logic [WrapW-1:0] res;
    inc = {1'b0, bank} + 4'd1;
    case (wrap)
      4'd0, 4'd1: res = '0;
      4'd2:       res = {3'b000, inc[0]};
      4'd3:       res = (inc >= 4'd6) ? inc - 4'd6 : ((inc >= 4'd3) ? inc - 4'd3 : inc);
      4'd4:       res = {2'b00, inc[1:0]};
      default:    res = (inc >= wrap) ? inc - wrap : inc;
    endcase
    return res[BankW-1:0];
  endfunction

  // Configuration registers
  logic [TickW-1:0] timeout_r;
  logic             switch_off_r;
  logic [WrapW-1:0] wrap_r;

  // Pad state
  buttons_t         buttons_r, buttons_nxt;
  logic             sel_r, sel_nxt;
  logic [BankW-1:0] bank_r, bank_nxt;
  logic [TickW-1:0] ticks_r, ticks_nxt;

  // Result register
  logic             out_valid_r;
  lines_t           out_lines_r;
  logic [BankW-1:0] out_bank_r;

  logic             in_fire;
  logic [BankW-1:0] bank_pre;
  logic [BankW-1:0] bank_mid;
  lines_t           lines_nxt;
  req_t             req;

  assign req      = req_t'(in_req_type);
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Write configuration registers; out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r    <= TimeoutReset;
      switch_off_r <= 1'b0;
      wrap_r       <= WrapReset;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TIMEOUT:    timeout_r    <= cfg_wdata;
        CFG_SWITCH_OFF: switch_off_r <= cfg_wdata[0];
        CFG_WRAP:       wrap_r       <= cfg_wdata[WrapW-1:0];
        default:        ;
      endcase
    end
  end

  // Apply the request between two timeout checks
  always_comb begin
    bank_pre    = (bank_r != '0 && ticks_r >= timeout_r) ? '0 : bank_r;
    bank_mid    = bank_pre;
    buttons_nxt = buttons_r;
    sel_nxt     = sel_r;
    ticks_nxt   = ticks_r;
    case (req)
      REQ_SELECT: begin
        if (in_th_level != sel_r) begin
          sel_nxt = in_th_level;
          if (in_th_level) begin
            bank_mid  = (switch_off_r || wrap_r == '0) ? '0 : wrap_next(bank_pre, wrap_r);
            ticks_nxt = '0;
          end
        end
      end
      REQ_BUTTON: begin
        for (int i = 0; i < NumButtons; i++) begin
          if (in_button_index == 4'(i)) begin
            buttons_nxt[i] = in_button_down;
          end
        end
      end
      REQ_TICK: begin
        if (ticks_r != TickMax) begin
          ticks_nxt = ticks_r + 1'b1;
        end
      end
      default: ;
    endcase
    bank_nxt = (bank_mid != '0 && ticks_nxt >= timeout_r) ? '0 : bank_mid;
  end

  sbp_line_map u_line_map (
    .buttons   (buttons_nxt),
    .sel_level (sel_nxt),
    .bank      (bank_nxt),
    .lines     (lines_nxt)
  );

  // Advance pad state on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buttons_r <= '0;
      sel_r     <= 1'b0;
      bank_r    <= '0;
      ticks_r   <= '0;
    end else if (in_fire) begin
      buttons_r <= buttons_nxt;
      sel_r     <= sel_nxt;
      bank_r    <= bank_nxt;
      ticks_r   <= ticks_nxt;
    end
  end

  // Result register: load on input transfer, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_lines_r <= lines_nxt;
      out_bank_r  <= bank_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_lines = out_lines_r.data;
  assign out_line_tl    = out_lines_r.tl;
  assign out_line_tr    = out_lines_r.tr;
  assign out_line_th    = out_lines_r.th;
  assign out_bank_now   = out_bank_r;

`ifndef ASSERT_OFF
  // Reported bank tracks the state after the transfer
  a_bank_matches: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (out_bank_now == bank_r))
    else $error("reported bank differs from bank state");

  // Rising select edge with switching off lands on bank 0 and clears ticks
  a_switch_off: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && req == REQ_SELECT && in_th_level && !sel_r && switch_off_r)
      |=> (bank_r == '0 && ticks_r == '0))
    else $error("rising edge with switching off did not clear bank");

  // TH line is low exactly for banks above three
  a_th_bank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_line_th == (out_bank_now <= BankThree)))
    else $error("TH level inconsistent with bank");

  // Saturated tick count stays put unless a rising edge clears it
  a_tick_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (ticks_r == TickMax) |=> (ticks_r == TickMax || ticks_r == '0))
    else $error("tick count left saturation");

  // A stalled result is not overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_fire)
    else $error("input transferred over a stalled result");
`endif

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for six_button_pad_bank_mux: drives items, predicts every result.
// Depends on sbp_pkg and the block's RTL; the scoreboard class lives inside the top module.

module testbench
  import sbp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Expected or observed pad levels together with the bank counter
  typedef struct packed {
    lines_t           lines;
    logic [BankW-1:0] bank;
  } pad_result_t;

  // Pad state tracker and store of pending line levels
  class pad_scoreboard;
    logic [TickW-1:0] timeout;
    logic             switch_off;
    logic [WrapW-1:0] wrap;
    buttons_t         held;
    logic             sel;
    logic [BankW-1:0] bank;
    logic [TickW-1:0] ticks;
    pad_result_t      pending_levels[$];
    int               errors;

    function new();
      timeout    = TimeoutReset;
      switch_off = 1'b0;
      wrap       = WrapReset;
      held       = '0;
      sel        = 1'b0;
      bank       = '0;
      ticks      = '0;
      errors     = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [TickW-1:0] value);
      case (idx)
        CFG_TIMEOUT:    timeout = value;
        CFG_SWITCH_OFF: switch_off = value[0];
        CFG_WRAP:       wrap = value[WrapW-1:0];
        default:        ;
      endcase
    endfunction

    // Drop a nonzero bank once the select edge is old enough
    function void expire_bank();
      if (bank != '0 && ticks >= timeout) bank = '0;
    endfunction

    // Advance the pad state by one accepted input and queue its line levels
    function void note_transfer(req_t req, logic th, logic [3:0] idx, logic down);
      pad_result_t r;
      int next_bank;
      expire_bank();
      case (req)
        REQ_SELECT: begin
          if (th != sel) begin
            sel = th;
            if (th) begin
              if (switch_off || wrap == '0) begin
                bank = '0;
              end else begin
                next_bank = (int'(bank) + 1) % int'(wrap);
                bank = next_bank[BankW-1:0];
              end
              ticks = '0;
            end
          end
        end
        REQ_BUTTON: if (idx <= BtnMode) held[idx] = down;
        REQ_TICK:   if (ticks != TickMax) ticks = ticks + 1'b1;
        default:    ;
      endcase
      expire_bank();

      r = '0;
      r.bank = bank;
      if (bank <= BankThree) begin
        r.lines.th = 1'b1;
        if (sel) begin
          r.lines.tl = ~held[BtnB];
          r.lines.tr = ~held[BtnC];
          if (bank == BankThree)
            r.lines.data = ~{held[BtnMode], held[BtnX], held[BtnY], held[BtnZ]};
          else
            r.lines.data = ~{held[BtnRight], held[BtnLeft], held[BtnDown], held[BtnUp]};
        end else begin
          r.lines.tl = ~held[BtnA];
          r.lines.tr = ~held[BtnStart];
          if (bank == BankThree)
            r.lines.data = 4'hF;
          else if (bank == BankTwo)
            r.lines.data = 4'h0;
          else
            r.lines.data = {2'b00, ~held[BtnDown], ~held[BtnUp]};
        end
      end
      pending_levels.push_back(r);
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
                 act_val);
      end
    endfunction

    // Match one result transfer against the oldest pending levels
    function void check_transfer(pad_result_t act);
      pad_result_t exp_r;
      if (pending_levels.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual %h", $time, act);
        return;
      end
      exp_r = pending_levels.pop_front();
      compare_field("data_lines", int'(exp_r.lines.data), int'(act.lines.data));
      compare_field("line_tl", int'(exp_r.lines.tl), int'(act.lines.tl));
      compare_field("line_tr", int'(exp_r.lines.tr), int'(act.lines.tr));
      compare_field("line_th", int'(exp_r.lines.th), int'(act.lines.th));
      compare_field("bank_now", int'(exp_r.bank), int'(act.bank));
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [1:0]       in_req_type;
  logic             in_th_level;
  logic [3:0]       in_button_index;
  logic             in_button_down;
  logic             out_valid;
  logic             out_ready;
  logic [3:0]       out_data_lines;
  logic             out_line_tl;
  logic             out_line_tr;
  logic             out_line_th;
  logic [BankW-1:0] out_bank_now;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [TickW-1:0] cfg_wdata;

  pad_scoreboard sb = new();
  int burst_left = 0;

  six_button_pad_bank_mux dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_th_level     (in_th_level),
    .in_button_index (in_button_index),
    .in_button_down  (in_button_down),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data_lines  (out_data_lines),
    .out_line_tl     (out_line_tl),
    .out_line_tr     (out_line_tr),
    .out_line_th     (out_line_th),
    .out_bank_now    (out_bank_now),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Present one item at the falling edge, hold it until the transfer
  task automatic send_item(req_t req, logic th, logic [3:0] idx, logic down);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid        = 1'b1;
    in_req_type     = req;
    in_th_level     = th;
    in_button_index = idx;
    in_button_down  = down;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_transfer(req, th, idx, down);
    burst_left--;
    @(negedge clk);
  endtask

  // Mix of select toggles, ticks, button events and no-ops with random don't-care fields
  task automatic send_random_item();
    int pick;
    req_t req;
    logic th;
    logic [3:0] idx;
    logic down;
    pick = $urandom_range(0, 99);
    th   = 1'($urandom_range(0, 1));
    idx  = 4'($urandom_range(0, 15));
    down = 1'($urandom_range(0, 1));
    if (pick < 40) begin
      req = REQ_SELECT;
      if ($urandom_range(0, 9) < 8) th = ~sb.sel;
    end else if (pick < 70) begin
      req = REQ_TICK;
    end else if (pick < 95) begin
      req = REQ_BUTTON;
      if ($urandom_range(0, 7) != 0) idx = 4'($urandom_range(0, BtnMode));
    end else begin
      req = REQ_NOP;
    end
    send_item(req, th, idx, down);
  endtask

  // Hold off until every pending result has come back
  task automatic drain();
    in_valid   = 1'b0;
    burst_left = 0;
    while (sb.pending_levels.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [TickW-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    sb.set_reg(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Receiver: switch between randomly chosen stall patterns
  initial begin : result_stall
    int mode;
    int left;
    logic [15:0] mask;
    out_ready = 1'b0;
    left = 0;
    mode = 0;
    mask = '1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(8, 80);
        mask = 16'($urandom) | 16'h1;
      end
      left--;
      case (mode)
        0:       out_ready = 1'b1;
        1:       out_ready = $urandom_range(0, 9) < 7;
        2:       out_ready = (left % 4) == 0;
        default: out_ready = mask[left % 16];
      endcase
    end
  end

  // Check each result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_transfer({out_data_lines, out_line_tl, out_line_tr, out_line_th, out_bank_now});
  end

  initial begin : stimulus
    logic [TickW-1:0] timeouts[9];
    logic             offs[9];
    logic [WrapW-1:0] wraps[9];
    int ph;
    int n;

    in_valid        = 1'b0;
    in_req_type     = REQ_NOP;
    in_th_level     = 1'b0;
    in_button_index = '0;
    in_button_down  = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_TIMEOUT;
    cfg_wdata       = '0;
    rst_n           = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: ignored buttons, banks 0 to 3 with both select levels, no-op
    send_item(REQ_NOP, 1'b1, 4'hF, 1'b1);
    send_item(REQ_BUTTON, 1'b0, 4'(BtnUp), 1'b1);
    send_item(REQ_BUTTON, 1'b1, 4'(BtnMode), 1'b1);
    send_item(REQ_BUTTON, 1'b0, 4'd15, 1'b1);
    send_item(REQ_BUTTON, 1'b0, 4'd12, 1'b1);
    send_item(REQ_BUTTON, 1'b0, 4'(BtnA), 1'b1);
    send_item(REQ_BUTTON, 1'b0, 4'(BtnZ), 1'b1);
    send_item(REQ_SELECT, 1'b1, 4'd0, 1'b0);
    send_item(REQ_SELECT, 1'b1, 4'd0, 1'b0);
    send_item(REQ_SELECT, 1'b0, 4'd0, 1'b0);
    send_item(REQ_SELECT, 1'b1, 4'd0, 1'b0);
    send_item(REQ_SELECT, 1'b0, 4'd0, 1'b0);
    send_item(REQ_SELECT, 1'b1, 4'd0, 1'b0);
    send_item(REQ_SELECT, 1'b0, 4'd0, 1'b0);
    send_item(REQ_TICK, 1'b1, 4'd7, 1'b1);
    send_item(REQ_SELECT, 1'b1, 4'd0, 1'b0);
    send_item(REQ_BUTTON, 1'b0, 4'(BtnUp), 1'b0);
    send_item(REQ_BUTTON, 1'b0, 4'(BtnMode), 1'b0);
    send_item(REQ_BUTTON, 1'b0, 4'(BtnStart), 1'b1);
    send_item(REQ_BUTTON, 1'b0, 4'(BtnB), 1'b1);
    send_item(REQ_BUTTON, 1'b0, 4'(BtnC), 1'b1);
    send_item(REQ_SELECT, 1'b0, 4'd0, 1'b0);

    // Settings per phase: defaults, zero and max timeout, wrap 0, 1, 8 and above 8
    timeouts = '{TimeoutReset, 24'd5, 24'd0, 24'd1, TickMax, 24'd12,
                 24'($urandom_range(2, 40)), 24'($urandom_range(3, 30)), 24'd8};
    offs     = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
    wraps    = '{WrapReset, 4'd4, 4'd8, 4'd1, 4'd15, 4'd4, 4'd0, 4'd9,
                 4'($urandom_range(1, 15))};

    for (ph = 0; ph < 9; ph++) begin
      drain();
      write_reg(CFG_TIMEOUT, timeouts[ph]);
      write_reg(CFG_SWITCH_OFF, {{(TickW-1){1'b0}}, offs[ph]});
      write_reg(CFG_WRAP, {{(TickW-WrapW){1'b0}}, wraps[ph]});
      if (ph == 4) write_reg(CFG_UNUSED, 24'(~0));
      for (n = 0; n < 172; n++) send_random_item();
    end

    drain();
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.pending_levels.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

### filelist.f
sv/sbp_pkg.sv
sv/sbp_line_map.sv
sv/six_button_pad_bank_mux.sv
bench/testbench.sv
